// ===== rtl/core/kshr_pkg.sv =====
`default_nettype none
package kshr_pkg;

    localparam int NUM_ROWS    = 4;
    localparam int NUM_COLS    = 4;
    localparam int NUM_KEYS    = NUM_ROWS * NUM_COLS;
    localparam int NUM_PHASES  = 2 * NUM_ROWS;
    localparam int MAX_RESULTS = 20;

    localparam int ROW_W   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int COL_W   = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam int KIDX_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int PHASE_W = $clog2(NUM_PHASES);
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int EIDX_W  = $clog2(MAX_RESULTS);

    localparam int HOLD_W  = 6;
    localparam int COLIN_W = 4;
    localparam int KIND_W  = 2;
    localparam int KEY_W   = 5;
    localparam int ROWO_W  = 4;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 6'd40;

    localparam logic [KIND_W-1:0] EV_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] EV_PRESS   = 2'd1;
    localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

    typedef struct packed {
        logic              wr;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
    } ev_t;

    typedef struct packed {
        logic clear;
        logic start;
    } drain_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/kshr_core.sv =====
`default_nettype none
module kshr_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        hold_time_we,
    input  wire logic [kshr_pkg::HOLD_W-1:0] hold_time_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [kshr_pkg::COLIN_W-1:0] column_levels,
    input  wire logic                        drain_done,
    output kshr_pkg::ev_t                    ev,
    output kshr_pkg::drain_ctl_t             dctl,
    output logic [kshr_pkg::NUM_ROWS-1:0]    rows
);
    import kshr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_COL   = 2'd1;
    localparam logic [1:0] S_PASS  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    localparam logic [NUM_ROWS-1:0] ROW_MASK = '1;

    logic [1:0]          state_reg, state_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [HOLD_W-1:0]   hold_reg;
    logic                latch_reg, latch_next;
    logic [NUM_ROWS-1:0] rows_reg, rows_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [KIDX_W-1:0]   key_reg, key_next;
    logic                final_reg, final_next;
    logic [COLIN_W-1:0]  cols_reg, cols_next;
    logic [HOLD_W-1:0]   cnt_reg [NUM_KEYS];

    logic                cnt_we;
    logic [KIDX_W-1:0]   cnt_addr;
    logic [HOLD_W-1:0]   cnt_wdata;
    logic [HOLD_W-1:0]   dec_in, dec_out;
    logic [PHASE_W-1:0]  cur_phase;
    logic [KIDX_W-1:0]   seen_addr;
    logic                col_low;

    assign in_ready = (state_reg == S_IDLE);
    assign rows     = rows_reg;

    // shared decrement unit
    assign dec_in  = cnt_reg[key_reg];
    assign dec_out = (dec_in != '0) ? dec_in - HOLD_W'(1) : dec_in;

    assign cur_phase = (int'(phase_reg) >= NUM_PHASES) ? '0 : phase_reg;
    assign seen_addr = KIDX_W'(int'(row_reg) * NUM_COLS + int'(col_reg));
    assign col_low   = !cols_reg[col_reg];

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        latch_next = latch_reg;
        rows_next  = rows_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        key_next   = key_reg;
        final_next = final_reg;
        cols_next  = cols_reg;
        cnt_we     = 1'b0;
        cnt_addr   = key_reg;
        cnt_wdata  = dec_out;
        ev         = '0;
        dctl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dctl.clear = 1'b1;
                    cols_next  = column_levels;
                    row_next   = ROW_W'(cur_phase >> 1);
                    col_next   = '0;
                    key_next   = '0;
                    if (int'(cur_phase) + 1 >= NUM_PHASES)
                        phase_next = '0;
                    else
                        phase_next = cur_phase + PHASE_W'(1);
                    if (!cur_phase[0])
                    begin
                        rows_next  = ROW_MASK & ~(NUM_ROWS'(1) << ROW_W'(cur_phase >> 1));
                        final_next = 1'b1;
                        state_next = S_PASS;
                    end
                    else
                    begin
                        state_next = S_COL;
                    end
                end
            end
            S_COL:
            begin
                if (col_low)
                begin
                    cnt_we    = 1'b1;
                    cnt_addr  = seen_addr;
                    cnt_wdata = hold_reg;
                    if (!latch_reg)
                    begin
                        ev.wr      = 1'b1;
                        ev.kind    = EV_PRESS;
                        ev.key     = KEY_W'(seen_addr) + KEY_W'(1);
                        latch_next = 1'b1;
                    end
                    key_next   = '0;
                    final_next = 1'b0;
                    state_next = S_PASS;
                end
                else if (int'(col_reg) == NUM_COLS - 1)
                begin
                    key_next   = '0;
                    final_next = 1'b1;
                    state_next = S_PASS;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            S_PASS:
            begin
                cnt_we = 1'b1;
                if (dec_out == HOLD_W'(1))
                begin
                    ev.wr      = 1'b1;
                    ev.kind    = EV_RELEASE;
                    ev.key     = KEY_W'(key_reg) + KEY_W'(1);
                    latch_next = 1'b0;
                end
                key_next = key_reg + KIDX_W'(1);
                if (int'(key_reg) == NUM_KEYS - 1)
                begin
                    key_next = '0;
                    if (final_reg)
                    begin
                        dctl.start = 1'b1;
                        state_next = S_DRAIN;
                    end
                    else if (int'(col_reg) == NUM_COLS - 1)
                    begin
                        final_next = 1'b1;
                    end
                    else
                    begin
                        col_next   = col_reg + COL_W'(1);
                        state_next = S_COL;
                    end
                end
            end
            S_DRAIN:
            begin
                if (drain_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= '0;
            hold_reg  <= HOLD_RESET;
            latch_reg <= 1'b0;
            rows_reg  <= ROW_MASK;
            row_reg   <= '0;
            col_reg   <= '0;
            key_reg   <= '0;
            final_reg <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++)
                cnt_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            latch_reg <= latch_next;
            rows_reg  <= rows_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            key_reg   <= key_next;
            final_reg <= final_next;
            if (hold_time_we)
                hold_reg <= hold_time_wdata;
            if (cnt_we)
                cnt_reg[cnt_addr] <= cnt_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        cols_reg <= cols_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/kshr_evbuf.sv =====
`default_nettype none
module kshr_evbuf (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire kshr_pkg::ev_t              ev,
    input  wire kshr_pkg::drain_ctl_t       dctl,
    output logic                            drain_done,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [kshr_pkg::KIND_W-1:0]     event_kind,
    output logic [kshr_pkg::KEY_W-1:0]      key_number,
    output logic                            last_event
);
    import kshr_pkg::*;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_READ = 2'd1;
    localparam logic [1:0] D_SHOW = 2'd2;

    logic [KIND_W+KEY_W-1:0] mem [MAX_RESULTS];
    logic [1:0]              state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [EIDX_W-1:0]       rd_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic [KEY_W-1:0]        key_reg;
    logic                    last_reg;
    logic                    buf_we;

    assign buf_we     = ev.wr && (int'(count_reg) < MAX_RESULTS);
    assign out_valid  = (state_reg == D_SHOW);
    assign drain_done = out_valid && out_ready && last_reg;
    assign event_kind = kind_reg;
    assign key_number = key_reg;
    assign last_event = last_reg;

    always_ff @(posedge clk)
    begin
        if (buf_we)
            mem[EIDX_W'(count_reg)] <= {ev.kind, ev.key};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            count_reg <= '0;
            rd_reg    <= '0;
        end
        else
        begin
            if (dctl.clear)
                count_reg <= '0;
            else if (buf_we)
                count_reg <= count_reg + CNT_W'(1);
            case (state_reg)
                D_IDLE:
                begin
                    rd_reg <= '0;
                    // an event can land in the same cycle as start
                    if (dctl.start)
                        state_reg <= (count_reg == '0 && !buf_we) ? D_SHOW : D_READ;
                end
                D_READ:
                begin
                    state_reg <= D_SHOW;
                end
                D_SHOW:
                begin
                    if (out_ready)
                    begin
                        if (last_reg)
                            state_reg <= D_IDLE;
                        else
                        begin
                            rd_reg    <= rd_reg + EIDX_W'(1);
                            state_reg <= D_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    // output item, loaded from the buffer or as the no-event item
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && dctl.start)
        begin
            kind_reg <= EV_NONE;
            key_reg  <= '0;
            last_reg <= 1'b1;
        end
        else if (state_reg == D_READ)
        begin
            {kind_reg, key_reg} <= mem[rd_reg];
            last_reg            <= (CNT_W'(rd_reg) + CNT_W'(1) == count_reg);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/keypad_scan_hold_release_top.sv =====
// The first result item of a tick is shown once the column scan and the decrement passes
//   are done; with events, each item is read from the buffer before it is shown.
// A new tick is accepted only after the last result item of the previous one is taken,
//   so output stalls hold off the next tick; the 16-key decrement passes through the
//   single shared decrement unit, one key at a time.
// Reset: asynchronous, active low; counters, latch and phase clear, rows all high,
//   hold_time returns to 40.
`default_nettype none
module keypad_scan_hold_release_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        hold_time_we,
    input  wire logic [kshr_pkg::HOLD_W-1:0] hold_time_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [kshr_pkg::COLIN_W-1:0] column_levels,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [kshr_pkg::KIND_W-1:0]      event_kind,
    output logic [kshr_pkg::KEY_W-1:0]       key_number,
    output logic [kshr_pkg::ROWO_W-1:0]      row_drive,
    output logic                             last_event
);
    import kshr_pkg::*;

    ev_t                 ev;
    drain_ctl_t          dctl;
    logic                drain_done;
    logic [NUM_ROWS-1:0] rows;

    kshr_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .hold_time_we    (hold_time_we),
        .hold_time_wdata (hold_time_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .column_levels   (column_levels),
        .drain_done      (drain_done),
        .ev              (ev),
        .dctl            (dctl),
        .rows            (rows)
    );

    kshr_evbuf u_evbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev         (ev),
        .dctl       (dctl),
        .drain_done (drain_done),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .key_number (key_number),
        .last_event (last_event)
    );

    assign row_drive = ROWO_W'(rows);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while an item is shown");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an accepted item");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_event |=> !in_ready)
        else $error("tick ended before its last item");

    a_none_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_NONE |-> key_number == '0 && last_event)
        else $error("bad no-event item");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kshr_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DIR_ROWS    = 24;
    localparam int RAND_BLOCKS = 8;
    localparam int BLOCK_ITEMS = 17;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [ROWO_W-1:0] rows;
        logic              last;
    } key_event_t;

    typedef struct packed {
        logic               wr;
        logic [HOLD_W-1:0]  hold;
        logic [COLIN_W-1:0] cols;
        logic               typed;
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [ROWO_W-1:0]  rows;
    } scan_row_t;

    logic                clk;
    logic                rst_n;
    logic                hold_time_we;
    logic [HOLD_W-1:0]   hold_time_wdata;
    logic                in_valid;
    logic                in_ready;
    logic [COLIN_W-1:0]  column_levels;
    logic                out_valid;
    logic                out_ready;
    logic [KIND_W-1:0]   event_kind;
    logic [KEY_W-1:0]    key_number;
    logic [ROWO_W-1:0]   row_drive;
    logic                last_event;

    keypad_scan_hold_release_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .hold_time_we    (hold_time_we),
        .hold_time_wdata (hold_time_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .column_levels   (column_levels),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .event_kind      (event_kind),
        .key_number      (key_number),
        .row_drive       (row_drive),
        .last_event      (last_event)
    );

    // scanner state as the testbench sees it
    logic [HOLD_W-1:0]   hold_cnt [1:NUM_KEYS];
    logic [PHASE_W-1:0]  scan_ph;
    logic                press_held;
    logic [ROWO_W-1:0]   row_lv;
    logic [HOLD_W-1:0]   hold_val;

    logic [KIND_W-1:0]   tick_kind [MAX_RESULTS];
    logic [KEY_W-1:0]    tick_key [MAX_RESULTS];
    int                  tick_n;

    key_event_t          due_events [$];
    key_event_t          got_ev;
    scan_row_t           dir_tab [DIR_ROWS];

    bit                  idle_on;
    int                  errors;
    int                  cycles;
    int                  ticks_sent;
    int                  results_seen;
    int                  presses_seen;
    int                  releases_seen;
    int                  capped_ticks;
    int                  hold_writes;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
        errors++;
    endtask

    task automatic note_event(input logic [KIND_W-1:0] kind, input int key);
        if (tick_n < MAX_RESULTS)
        begin
            tick_kind[tick_n] = kind;
            tick_key[tick_n]  = KEY_W'(key);
            tick_n++;
        end
        else
            capped_ticks++;
    endtask

    task automatic hold_countdown();
        for (int k = 1; k <= NUM_KEYS; k++)
        begin
            if (hold_cnt[k] != '0)
                hold_cnt[k] = hold_cnt[k] - 1'b1;
            if (hold_cnt[k] == HOLD_W'(1))
            begin
                press_held = 1'b0;
                note_event(EV_RELEASE, k);
            end
        end
    endtask

    // one scan tick; queues the events it causes when keep is set
    task automatic scan_tick(input logic [COLIN_W-1:0] cols, input bit keep);
        int         r;
        int         key;
        int         capped_before;
        key_event_t ev;
        tick_n = 0;
        capped_before = capped_ticks;
        r = int'(scan_ph) >> 1;
        if (!scan_ph[0])
            row_lv = {ROWO_W{1'b1}} & ~(ROWO_W'(1) << r);
        else
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                if (!cols[c])
                begin
                    key = r * NUM_COLS + c + 1;
                    hold_cnt[key] = hold_val;
                    if (!press_held)
                    begin
                        note_event(EV_PRESS, key);
                        press_held = 1'b1;
                    end
                    hold_countdown();
                end
            end
        end
        scan_ph = (int'(scan_ph) == NUM_PHASES - 1) ? '0 : scan_ph + 1'b1;
        hold_countdown();
        if (capped_ticks != capped_before)
            capped_ticks = capped_before + 1;
        if (keep)
        begin
            if (tick_n == 0)
            begin
                ev = '{kind: EV_NONE, key: '0, rows: row_lv, last: 1'b1};
                due_events.push_back(ev);
            end
            for (int i = 0; i < tick_n; i++)
            begin
                ev = '{kind: tick_kind[i], key: tick_key[i], rows: row_lv,
                       last: (i == tick_n - 1)};
                due_events.push_back(ev);
            end
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_tick(input logic [COLIN_W-1:0] cols, input bit typed,
                             input key_event_t want);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid      = 1'b1;
        column_levels = cols;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        scan_tick(cols, !typed);
        if (typed)
            due_events.push_back(want);
        ticks_sent++;
        @(negedge clk);
    endtask

    // only with the scanner drained
    task automatic write_hold(input logic [HOLD_W-1:0] v);
        in_valid = 1'b0;
        while (due_events.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        hold_time_we    = 1'b1;
        hold_time_wdata = v;
        @(posedge clk);
        hold_val = v;
        hold_writes++;
        @(negedge clk);
        hold_time_we = 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, due_events.size());
            $display("keypad_scan_hold_release_top regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_events.size() == 0)
                report_mismatch("unexpected item, key", int'(key_number), 0);
            else
            begin
                got_ev = due_events.pop_front();
                if (event_kind != got_ev.kind)
                    report_mismatch("event_kind", int'(event_kind), int'(got_ev.kind));
                if (key_number != got_ev.key)
                    report_mismatch("key_number", int'(key_number), int'(got_ev.key));
                if (row_drive != got_ev.rows)
                    report_mismatch("row_drive", int'(row_drive), int'(got_ev.rows));
                if (last_event != got_ev.last)
                    report_mismatch("last_event", int'(last_event), int'(got_ev.last));
                if (got_ev.kind == EV_PRESS)
                    presses_seen++;
                if (got_ev.kind == EV_RELEASE)
                    releases_seen++;
            end
            results_seen++;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_ready = 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    end

    initial
    begin
        key_event_t         want;
        logic [COLIN_W-1:0] pat;
        logic [COLIN_W-1:0] cols;
        int                 left;
        int                 run;
        logic [HOLD_W-1:0]  h;

        clk             = 1'b0;
        rst_n           = 1'b0;
        hold_time_we    = 1'b0;
        hold_time_wdata = '0;
        in_valid        = 1'b0;
        column_levels   = '1;
        idle_on         = 1'b1;
        errors          = 0;
        cycles          = 0;
        ticks_sent      = 0;
        results_seen    = 0;
        presses_seen    = 0;
        releases_seen   = 0;
        capped_ticks    = 0;
        hold_writes     = 0;
        for (int k = 1; k <= NUM_KEYS; k++)
            hold_cnt[k] = '0;
        scan_ph    = '0;
        press_held = 1'b0;
        row_lv     = '1;
        hold_val   = HOLD_RESET;

        // wr, hold, cols, typed, kind, key, rows
        dir_tab[0]  = '{1'b0, 6'd0,  4'hF, 1'b1, EV_NONE,  5'd0, 4'hE};
        dir_tab[1]  = '{1'b0, 6'd0,  4'hF, 1'b1, EV_NONE,  5'd0, 4'hE};
        dir_tab[2]  = '{1'b0, 6'd0,  4'hF, 1'b1, EV_NONE,  5'd0, 4'hD};
        dir_tab[3]  = '{1'b0, 6'd0,  4'hE, 1'b1, EV_PRESS, 5'd5, 4'hD};
        dir_tab[4]  = '{1'b0, 6'd0,  4'hF, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[5]  = '{1'b0, 6'd0,  4'hF, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[6]  = '{1'b0, 6'd0,  4'hF, 1'b0, EV_NONE,  5'd0, 4'h0};
        // stagger the counters so that one row 3 tick overflows the event limit
        dir_tab[7]  = '{1'b1, 6'd25, 4'h0, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[8]  = '{1'b0, 6'd0,  4'hF, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[9]  = '{1'b1, 6'd20, 4'h0, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[10] = '{1'b0, 6'd0,  4'hF, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[11] = '{1'b1, 6'd14, 4'h0, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[12] = '{1'b0, 6'd0,  4'hF, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[13] = '{1'b1, 6'd8,  4'h0, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[14] = '{1'b0, 6'd0,  4'hF, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[15] = '{1'b1, 6'd2,  4'h0, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[16] = '{1'b1, 6'd63, 4'hF, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[17] = '{1'b0, 6'd0,  4'h0, 1'b0, EV_NONE,  5'd0, 4'h0};
        // hold times of zero and one never release
        dir_tab[18] = '{1'b1, 6'd0,  4'hF, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[19] = '{1'b0, 6'd0,  4'h5, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[20] = '{1'b1, 6'd1,  4'hF, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[21] = '{1'b0, 6'd0,  4'hA, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[22] = '{1'b1, 6'd40, 4'hF, 1'b0, EV_NONE,  5'd0, 4'h0};
        dir_tab[23] = '{1'b0, 6'd0,  4'h7, 1'b0, EV_NONE,  5'd0, 4'h0};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tab[i].wr)
                write_hold(dir_tab[i].hold);
            want = '{kind: dir_tab[i].kind, key: dir_tab[i].key,
                     rows: dir_tab[i].rows, last: 1'b1};
            send_tick(dir_tab[i].cols, dir_tab[i].typed, want);
        end

        want = '0;
        for (int b = 0; b < RAND_BLOCKS; b++)
        begin
            case (b)
                0:       h = 6'd2;
                1:       h = 6'd63;
                2, 4:    h = HOLD_W'($urandom_range(2, 8));
                default: h = HOLD_W'($urandom_range(2, 63));
            endcase
            write_hold(h);
            idle_on = (b < RAND_BLOCKS - 2);
            left = BLOCK_ITEMS;
            while (left > 0)
            begin
                // a key pattern held for a while, with some noise on top
                run = $urandom_range(4, 16);
                case ($urandom_range(0, 4))
                    0, 1:    pat = '1;
                    2, 3:    pat = ~(COLIN_W'(1) << $urandom_range(0, COLIN_W - 1));
                    default: pat = COLIN_W'($urandom_range(0, 15));
                endcase
                for (int j = 0; j < run && left > 0; j++)
                begin
                    cols = ($urandom_range(0, 7) == 0) ? COLIN_W'($urandom_range(0, 15)) : pat;
                    send_tick(cols, 1'b0, want);
                    left--;
                end
            end
        end

        in_valid = 1'b0;
        while (due_events.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (due_events.size() != 0)
            report_mismatch("results left over", due_events.size(), 0);

        $display("%0d scan ticks over %0d hold_time writes, %0d result items checked",
                 ticks_sent, hold_writes, results_seen);
        $display("%0d presses, %0d releases, %0d ticks past the event limit",
                 presses_seen, releases_seen, capped_ticks);
        if (errors == 0)
            $display("keypad_scan_hold_release_top regression: pass");
        else
            $display("keypad_scan_hold_release_top regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
